// File: src/gts_pkg.sv
// shared types, constants and register map of the grid trilinear sampler
package gts_pkg;

   localparam int GRID_X_DEF = 32;
   localparam int GRID_Y_DEF = 32;
   localparam int GRID_Z_DEF = 32;

   // widest floor index over the supported grid sizes (up to 256 per axis)
   localparam int IDX_W = 8;

   localparam int CSR_ADDR_W = 5;

   localparam logic [2:0] REG_GRID_DIMS     = 3'd0;
   localparam logic [2:0] REG_ORIGIN_X      = 3'd1;
   localparam logic [2:0] REG_ORIGIN_Y      = 3'd2;
   localparam logic [2:0] REG_ORIGIN_Z      = 3'd3;
   localparam logic [2:0] REG_INV_SPACING_X = 3'd4;
   localparam logic [2:0] REG_INV_SPACING_Y = 3'd5;
   localparam logic [2:0] REG_INV_SPACING_Z = 3'd6;

   localparam logic [1:0]  DIMS_2D       = 2'd2;
   localparam logic [1:0]  DIMS_RESET    = 2'd3;
   localparam logic [31:0] INV_SP_RESET  = 32'h0001_0000;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam logic [16:0] WEIGHT_ONE = 17'h1_0000;

   localparam logic MODE_WRITE = 1'b0;

   typedef enum logic [1:0] {
      WSEL_TX,
      WSEL_TY,
      WSEL_TZ
   } wsel_type;

   typedef struct packed {
      logic               mode;
      logic [4:0]         cell_x;
      logic [4:0]         cell_y;
      logic [4:0]         cell_z;
      logic signed [31:0] write_value;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] sample;
      logic               off_grid;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0]         grid_dims;
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic [31:0]        inv_spacing_x;
      logic [31:0]        inv_spacing_y;
      logic [31:0]        inv_spacing_z;
   } cfg_type;

   typedef struct packed {
      logic       capture;
      logic       clr_en;
      logic       wr_en;
      logic       map_init;
      logic       map_en;
      logic [1:0] map_axis;
      logic       map_eval;
      logic [1:0] eval_axis;
      logic       rd_en;
      logic [2:0] rd_corner;
      logic       ld_en;
      logic [2:0] ld_idx;
      logic       lerp_en;
      logic [2:0] wr_idx;
      wsel_type   wsel;
      logic       out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic mode;
      logic ok;
      logic three;
   } dp_status_type;

endpackage

// File: src/grid_trilinear_sampler_unit.sv
// top level of the grid trilinear sampler
// a write item goes from decode straight to the result; a query maps each axis, reads
//   the corners and runs the lerp chain, and skips the reads and lerps off the grid
// throughput: one item at a time, the next transfer in the cycle after the result loads;
//   the corners are read in turn on the single read port of the grid store and the
//   lerps run in turn on the single lerp multiplier
// reset: synchronous; registers return to defaults and the grid store is cleared one
//   entry per cycle over all GRID_X*GRID_Y*GRID_Z (32768 by default) before req_ready rises
module grid_trilinear_sampler_unit #(
   parameter int GRID_X = gts_pkg::GRID_X_DEF,
   parameter int GRID_Y = gts_pkg::GRID_Y_DEF,
   parameter int GRID_Z = gts_pkg::GRID_Z_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // input item channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  gts_pkg::req_payload_type           req_data,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output gts_pkg::rsp_payload_type           rsp_data,
   // configuration port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [gts_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   gts_pkg::cfg_type       cfg;
   gts_pkg::dp_cmd_type    cmd;
   gts_pkg::dp_status_type status;

   // register access never waits
   assign pready = 1'b1;

   // register file: dims, origin and reciprocal spacing
   gts_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   // sequencer: clear pass, then map -> corner reads -> lerp chain per query;
   // the output register lets a new transfer in while a result waits
   gts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: grid store, one multiplier for mapping, one for lerps
   gts_dp #(
      .GRID_X (GRID_X),
      .GRID_Y (GRID_Y),
      .GRID_Z (GRID_Z)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

// File: src/gts_csr.sv
// configuration register file with apb-style access
module gts_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [gts_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output gts_pkg::cfg_type                    cfg
);

   gts_pkg::cfg_type cfg_ff;
   logic [2:0]       idx;
   logic             wr;

   assign idx = paddr[4:2];
   assign wr  = psel && penable && pwrite;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_dims     <= gts_pkg::DIMS_RESET;
         cfg_ff.origin_x      <= '0;
         cfg_ff.origin_y      <= '0;
         cfg_ff.origin_z      <= '0;
         cfg_ff.inv_spacing_x <= gts_pkg::INV_SP_RESET;
         cfg_ff.inv_spacing_y <= gts_pkg::INV_SP_RESET;
         cfg_ff.inv_spacing_z <= gts_pkg::INV_SP_RESET;
      end else if (wr) begin
         unique case (idx)
            gts_pkg::REG_GRID_DIMS:     cfg_ff.grid_dims     <= pwdata[1:0];
            gts_pkg::REG_ORIGIN_X:      cfg_ff.origin_x      <= pwdata;
            gts_pkg::REG_ORIGIN_Y:      cfg_ff.origin_y      <= pwdata;
            gts_pkg::REG_ORIGIN_Z:      cfg_ff.origin_z      <= pwdata;
            gts_pkg::REG_INV_SPACING_X: cfg_ff.inv_spacing_x <= pwdata;
            gts_pkg::REG_INV_SPACING_Y: cfg_ff.inv_spacing_y <= pwdata;
            gts_pkg::REG_INV_SPACING_Z: cfg_ff.inv_spacing_z <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         gts_pkg::REG_GRID_DIMS:     prdata = {30'd0, cfg_ff.grid_dims};
         gts_pkg::REG_ORIGIN_X:      prdata = cfg_ff.origin_x;
         gts_pkg::REG_ORIGIN_Y:      prdata = cfg_ff.origin_y;
         gts_pkg::REG_ORIGIN_Z:      prdata = cfg_ff.origin_z;
         gts_pkg::REG_INV_SPACING_X: prdata = cfg_ff.inv_spacing_x;
         gts_pkg::REG_INV_SPACING_Y: prdata = cfg_ff.inv_spacing_y;
         gts_pkg::REG_INV_SPACING_Z: prdata = cfg_ff.inv_spacing_z;
         default:                    prdata = '0;
      endcase
   end

endmodule

// File: src/gts_ctrl.sv
// sequencer for clear pass, writes and interpolated queries
module gts_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  gts_pkg::dp_status_type    status,
   output gts_pkg::dp_cmd_type       cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_MAP,
      ST_CHECK,
      ST_READ,
      ST_LERP,
      ST_FINISH
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [3:0] n_axes, n_corners, n_steps, wr_pos;

   assign n_axes    = status.three ? 4'd3 : 4'd2;
   assign n_corners = status.three ? 4'd8 : 4'd4;
   assign n_steps   = status.three ? 4'd7 : 4'd3;
   assign wr_pos    = n_corners - cnt_ff - 4'd2;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.mode == gts_pkg::MODE_WRITE) begin
               cmd.wr_en = 1'b1;
               state_in  = ST_FINISH;
            end else begin
               cmd.map_init = 1'b1;
               cnt_in       = '0;
               state_in     = ST_MAP;
            end
         end
         ST_MAP: begin
            if (cnt_ff < n_axes) begin
               cmd.map_en   = 1'b1;
               cmd.map_axis = cnt_ff[1:0];
            end
            if (cnt_ff != 4'd0) begin
               cmd.map_eval  = 1'b1;
               cmd.eval_axis = 2'(cnt_ff - 4'd1);
            end
            if (cnt_ff == n_axes) state_in = ST_CHECK;
            else cnt_in = cnt_ff + 4'd1;
         end
         ST_CHECK: begin
            cnt_in   = '0;
            state_in = status.ok ? ST_READ : ST_FINISH;
         end
         ST_READ: begin
            if (cnt_ff < n_corners) begin
               cmd.rd_en     = 1'b1;
               cmd.rd_corner = cnt_ff[2:0];
            end
            if (cnt_ff != 4'd0) begin
               cmd.ld_en  = 1'b1;
               cmd.ld_idx = 3'(cnt_ff - 4'd1);
            end
            if (cnt_ff == n_corners) begin
               cnt_in   = '0;
               state_in = ST_LERP;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ST_LERP: begin
            cmd.lerp_en = 1'b1;
            cmd.wr_idx  = wr_pos[2:0];
            priority if (cnt_ff < (status.three ? 4'd4 : 4'd2)) cmd.wsel = gts_pkg::WSEL_TX;
            else if (cnt_ff < (status.three ? 4'd6 : 4'd3))     cmd.wsel = gts_pkg::WSEL_TY;
            else                                                cmd.wsel = gts_pkg::WSEL_TZ;
            if (cnt_ff == n_steps - 4'd1) state_in = ST_FINISH;
            else cnt_in = cnt_ff + 4'd1;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

   // a result only appears from a finished item
   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.out_load))
      else $error("result raised without load");

   // no transfer is taken before the clear pass ends
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_en |-> !(req_valid && req_ready))
      else $error("transfer accepted during clear");

endmodule

// File: src/gts_dp.sv
// grid store, coordinate mapping and lerp datapath
module gts_dp #(
   parameter int GRID_X = gts_pkg::GRID_X_DEF,
   parameter int GRID_Y = gts_pkg::GRID_Y_DEF,
   parameter int GRID_Z = gts_pkg::GRID_Z_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  gts_pkg::cfg_type           cfg,
   input  gts_pkg::req_payload_type   req_data,
   input  gts_pkg::dp_cmd_type        cmd,
   output gts_pkg::dp_status_type     status,
   output gts_pkg::rsp_payload_type   rsp_data
);

   localparam int DEPTH = GRID_X * GRID_Y * GRID_Z;
   localparam int AW    = $clog2(DEPTH);
   localparam int XW    = $clog2(GRID_X);
   localparam int YW    = $clog2(GRID_Y);
   localparam int ZW    = $clog2(GRID_Z);

   logic [31:0] mem [DEPTH];

   gts_pkg::req_payload_type in_ff;
   gts_pkg::rsp_payload_type rsp_ff;
   logic [AW-1:0]  clr_addr_ff;
   logic [63:0]    prod_ff;
   logic           neg_ff;
   logic           ok_ff;
   logic [XW-1:0]  ix_ff;
   logic [YW-1:0]  iy_ff;
   logic [ZW-1:0]  iz_ff;
   logic [16:0]    tx_ff, ty_ff, tz_ff;
   logic [31:0]    rdata_ff;
   logic [31:0]    v_ff [8];

   logic           three, clear_done, wr_ok;
   logic [4:0]     cz_eff;
   logic [AW-1:0]  wr_addr, base_addr, rd_addr, corner_off;
   logic [31:0]    pos_sel, org_sel, inv_sel;
   logic [32:0]    diff;
   logic [47:0]    u, lim;
   logic [gts_pkg::IDX_W-1:0] nm1, idx;
   logic [16:0]    t_ax, t_sel;
   logic           axis_ok;
   logic signed [32:0] ldiff;
   logic signed [17:0] lt;
   logic signed [50:0] lprod, lrnd;
   logic [31:0]    lres;

   assign three      = (cfg.grid_dims != gts_pkg::DIMS_2D);
   assign clear_done = (clr_addr_ff == AW'(DEPTH - 1));

   assign status.clear_done = clear_done;
   assign status.mode       = in_ff.mode;
   assign status.ok         = ok_ff;
   assign status.three      = three;
   assign rsp_data          = rsp_ff;

   // write item index check and address
   assign cz_eff = three ? in_ff.cell_z : 5'd0;
   assign wr_ok  = ({4'd0, in_ff.cell_x} < 9'(GRID_X)) &&
                   ({4'd0, in_ff.cell_y} < 9'(GRID_Y)) &&
                   ({4'd0, cz_eff}       < 9'(GRID_Z));
   assign wr_addr = (AW'(cz_eff) * AW'(GRID_Y) + AW'(in_ff.cell_y)) * AW'(GRID_X)
                    + AW'(in_ff.cell_x);

   // corner addresses around the floor index
   assign base_addr  = (AW'(iz_ff) * AW'(GRID_Y) + AW'(iy_ff)) * AW'(GRID_X) + AW'(ix_ff);
   assign corner_off = AW'(cmd.rd_corner[0])
                     + (cmd.rd_corner[1] ? AW'(GRID_X) : '0)
                     + (cmd.rd_corner[2] ? AW'(GRID_X * GRID_Y) : '0);
   assign rd_addr    = base_addr + corner_off;

   // mapping: offset times reciprocal spacing
   always_comb begin
      unique case (cmd.map_axis)
         gts_pkg::AXIS_X: begin
            pos_sel = in_ff.pos_x; org_sel = cfg.origin_x; inv_sel = cfg.inv_spacing_x;
         end
         gts_pkg::AXIS_Y: begin
            pos_sel = in_ff.pos_y; org_sel = cfg.origin_y; inv_sel = cfg.inv_spacing_y;
         end
         default: begin
            pos_sel = in_ff.pos_z; org_sel = cfg.origin_z; inv_sel = cfg.inv_spacing_z;
         end
      endcase
   end
   assign diff = {pos_sel[31], pos_sel} - {org_sel[31], org_sel};

   // mapping: range check, floor index and weight
   always_comb begin
      unique case (cmd.eval_axis)
         gts_pkg::AXIS_X: nm1 = gts_pkg::IDX_W'(GRID_X - 1);
         gts_pkg::AXIS_Y: nm1 = gts_pkg::IDX_W'(GRID_Y - 1);
         default:         nm1 = gts_pkg::IDX_W'(GRID_Z - 1);
      endcase
      u       = prod_ff[63:16];
      lim     = {24'd0, nm1, 16'd0};
      axis_ok = !neg_ff && (u <= lim);
      idx     = u[16 +: gts_pkg::IDX_W];
      t_ax    = {1'b0, u[15:0]};
      if (idx == nm1) begin
         idx  = nm1 - gts_pkg::IDX_W'(1);
         t_ax = gts_pkg::WEIGHT_ONE;
      end
   end

   // lerp with round half up
   always_comb begin
      unique case (cmd.wsel)
         gts_pkg::WSEL_TX: t_sel = tx_ff;
         gts_pkg::WSEL_TY: t_sel = ty_ff;
         default:          t_sel = tz_ff;
      endcase
      ldiff = signed'({v_ff[1][31], v_ff[1]}) - signed'({v_ff[0][31], v_ff[0]});
      lt    = signed'({1'b0, t_sel});
      lprod = ldiff * lt;
      lrnd  = lprod + 51'sd32768;
      lres  = v_ff[0] + lrnd[47:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clr_en && !clear_done) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_en) begin
         mem[clr_addr_ff] <= '0;
      end else if (cmd.wr_en && wr_ok) begin
         mem[wr_addr] <= in_ff.write_value;
      end
      if (cmd.rd_en) rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) in_ff <= req_data;
      if (cmd.map_en) begin
         prod_ff <= 64'(diff[31:0]) * 64'(inv_sel);
         neg_ff  <= diff[32] && (inv_sel != '0);
      end
      if (cmd.map_init) begin
         ok_ff <= 1'b1;
         iz_ff <= '0;
         tz_ff <= '0;
      end
      if (cmd.map_eval) begin
         ok_ff <= ok_ff && axis_ok;
         unique case (cmd.eval_axis)
            gts_pkg::AXIS_X: begin ix_ff <= XW'(idx); tx_ff <= t_ax; end
            gts_pkg::AXIS_Y: begin iy_ff <= YW'(idx); ty_ff <= t_ax; end
            default:         begin iz_ff <= ZW'(idx); tz_ff <= t_ax; end
         endcase
      end
      if (cmd.ld_en) v_ff[cmd.ld_idx] <= rdata_ff;
      if (cmd.lerp_en) begin
         // shift the pending pairs down; the new value lands in its own slot
         for (int i = 0; i < 6; i++) begin
            if (3'(i) != cmd.wr_idx) v_ff[i] <= v_ff[i + 2];
         end
         v_ff[cmd.wr_idx] <= lres;
      end
      if (cmd.out_load) begin
         if (in_ff.mode == gts_pkg::MODE_WRITE) begin
            rsp_ff.sample   <= '0;
            rsp_ff.off_grid <= !wr_ok;
         end else begin
            rsp_ff.sample   <= ok_ff ? v_ff[0] : '0;
            rsp_ff.off_grid <= !ok_ff;
         end
      end
   end

endmodule
